[rtl/dsvu_pkg.sv]
// ----------------------------------------------------------------------------
// dsvu_pkg
// Shared types and constants for the Dirichlet voxel class-count update block.
// ----------------------------------------------------------------------------
`default_nettype none

package dsvu_pkg;

  localparam int NUM_CLASSES_DEF = 4;

  localparam int CNT_W    = 32;
  localparam int PRIOR_W  = 21;
  localparam int MASK_W   = 4;
  localparam int EV_NUM   = 4;   // evidence fields carried by one item
  localparam int OP_W     = 3;
  localparam int SEL_W    = 2;
  localparam int CLASS_W  = 2;
  localparam int PROB_W   = 17;
  localparam int VAR_W    = 24;
  localparam int CFG_IDX_W = 1;

  localparam int S_DATA_W = 136;
  localparam int M_DATA_W = 48;

  localparam logic [CNT_W-1:0]   COUNT_RESET = 32'd32768;
  localparam logic [PRIOR_W-1:0] PRIOR_RESET = 21'd32768;
  localparam logic [CNT_W-1:0]   ONE_Q16_CNT = 32'd65536;
  localparam logic [PROB_W-1:0]  ONE_Q16     = 17'd65536;
  localparam logic [CNT_W-1:0]   DECAY_RECIP = 32'hAAAA_AAAB;  // ceil(2^33 / 3)

  // shared divider: quotient bits per cycle and chunk counts per division
  localparam int QUO_W    = 24;
  localparam int DIV_STEP = 4;
  localparam int CHUNK_W  = 3;
  localparam logic [CHUNK_W-1:0] PROB_CHUNKS = 3'd5;  // 20 quotient bits
  localparam logic [CHUNK_W-1:0] VAR_CHUNKS  = 3'd6;  // 24 quotient bits

  localparam logic [CFG_IDX_W-1:0] REG_PRIOR    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DYN_MASK = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 3'd0,
    OP_DECAY = 3'd1,
    OP_LOAD  = 3'd2,
    OP_RESET = 3'd3,
    OP_QUERY = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_PROB,
    ST_PWAIT,
    ST_MUL,
    ST_VAR,
    ST_VWAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                start;
    logic [CHUNK_W-1:0]  chunks;
  } div_req_t;

endpackage : dsvu_pkg

`default_nettype wire

[rtl/dsvu_lane.sv]
// ----------------------------------------------------------------------------
// dsvu_lane
// One class count register and its update for every operation.
// ----------------------------------------------------------------------------
`default_nettype none

module dsvu_lane (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire dsvu_pkg::op_e               op_i,
  input  wire logic [dsvu_pkg::CNT_W-1:0]  evid_i,
  input  wire logic                        dyn_i,
  input  wire logic [dsvu_pkg::PRIOR_W-1:0] prior_i,
  input  wire logic                        hit_i,
  output logic      [dsvu_pkg::CNT_W-1:0]  count_o,
  output logic                             divided_o
);
  import dsvu_pkg::*;

  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W:0]     sum;
  logic [2*CNT_W-1:0] recip_prod;
  logic [CNT_W-2:0]   third;
  logic [1:0]         rem3;
  logic [CNT_W-1:0]   two_thirds;
  logic               above_one;

  // floor(2c/3) = 2*floor(c/3) + (c mod 3 == 2); c mod 3 needs only two bits
  assign recip_prod = (2*CNT_W)'(count_q) * (2*CNT_W)'(DECAY_RECIP);
  assign third      = recip_prod[2*CNT_W-1:CNT_W+1];
  assign rem3       = count_q[1:0] - (third[1:0] + {third[0], 1'b0});
  assign two_thirds = {third, 1'b0} + CNT_W'(rem3 == 2'd2);
  assign above_one  = count_q > ONE_Q16_CNT;
  assign sum        = {1'b0, count_q} + {1'b0, evid_i};

  always_comb begin
    count_d = count_q;
    case (op_i)
      OP_ADD: begin
        count_d = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
      end
      OP_DECAY: begin
        if (dyn_i) count_d = above_one ? two_thirds : '0;
      end
      OP_LOAD: begin
        if (dyn_i) count_d = evid_i;
      end
      OP_RESET: begin
        if (hit_i) count_d = CNT_W'(prior_i);
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (en_i) begin
      count_q <= count_d;
    end
  end

  assign count_o   = count_q;
  assign divided_o = (op_i == OP_DECAY) && dyn_i && above_one;

endmodule : dsvu_lane

`default_nettype wire

[rtl/dsvu_merge.sv]
// ----------------------------------------------------------------------------
// dsvu_merge
// Registered merge of the lane counts: total, first argmax, selected count.
// ----------------------------------------------------------------------------
`default_nettype none

module dsvu_merge #(
  parameter int NUM_CLASSES = dsvu_pkg::NUM_CLASSES_DEF,
  parameter int IW = $clog2(NUM_CLASSES),
  parameter int TW = dsvu_pkg::CNT_W + $clog2(NUM_CLASSES)
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          load_i,
  input  wire logic [NUM_CLASSES-1:0][dsvu_pkg::CNT_W-1:0]   counts_i,
  input  wire logic [dsvu_pkg::SEL_W-1:0]                    sel_i,
  output logic      [TW-1:0]                                 total_o,
  output logic      [IW-1:0]                                 best_o,
  output logic      [dsvu_pkg::CNT_W-1:0]                    sel_count_o,
  output logic                                               sel_ok_o
);
  import dsvu_pkg::*;

  localparam int P2 = 1 << IW;

  logic [P2-1:0][CNT_W-1:0] tv;
  logic [P2-1:0][IW-1:0]    ti;
  logic [TW-1:0]            total_d;
  logic                     sel_ok_d;
  logic [IW-1:0]            sel_idx;

  // pairwise tree; strict compare keeps the lower index on ties
  always_comb begin
    for (int k = 0; k < P2; k++) begin
      tv[k] = (k < NUM_CLASSES) ? counts_i[k % NUM_CLASSES] : '0;
      ti[k] = IW'(k);
    end
    for (int l = 0; l < IW; l++) begin
      for (int j = 0; j < P2/2; j++) begin
        if (j < (P2 >> (l+1))) begin
          if (tv[2*j+1] > tv[2*j]) begin
            tv[j] = tv[2*j+1];
            ti[j] = ti[2*j+1];
          end else begin
            tv[j] = tv[2*j];
            ti[j] = ti[2*j];
          end
        end
      end
    end
  end

  always_comb begin
    total_d = '0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      total_d = total_d + TW'(counts_i[k]);
    end
  end

  assign sel_ok_d = 32'(sel_i) < NUM_CLASSES;
  assign sel_idx  = IW'(sel_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      total_o     <= total_d;
      best_o      <= ti[0];
      sel_count_o <= sel_ok_d ? counts_i[sel_idx] : '0;
      sel_ok_o    <= sel_ok_d;
    end
  end

endmodule : dsvu_merge

`default_nettype wire

[rtl/dsvu_div.sv]
// ----------------------------------------------------------------------------
// dsvu_div
// Shared restoring divider, DIV_STEP quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dsvu_div #(
  parameter int DW = dsvu_pkg::CNT_W + 3
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dsvu_pkg::div_req_t            req_i,
  input  wire logic [DW-1:0]                 rem_init_i,  // numerator high part, below divisor
  input  wire logic [dsvu_pkg::QUO_W-1:0]    num_lo_i,    // remaining numerator bits, MSB first
  input  wire logic [DW-1:0]                 divisor_i,
  output logic                               done_o,
  output logic      [dsvu_pkg::QUO_W-1:0]    quo_o
);
  import dsvu_pkg::*;

  logic [DW-1:0]      rem_q, rem_d, div_q;
  logic [QUO_W-1:0]   num_q, num_d, quo_q, quo_d;
  logic [CHUNK_W-1:0] cnt_q;
  logic               busy_q, done_q;

  always_comb begin
    logic [DW:0] t;
    rem_d = rem_q;
    num_d = num_q;
    quo_d = quo_q;
    for (int k = 0; k < DIV_STEP; k++) begin
      t = {rem_d, num_d[QUO_W-1]};
      if (t >= {1'b0, div_q}) begin
        t     = t - {1'b0, div_q};
        quo_d = {quo_d[QUO_W-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[QUO_W-2:0], 1'b0};
      end
      rem_d = t[DW-1:0];
      num_d = {num_d[QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.chunks;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CHUNK_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= rem_init_i;
      num_q <= num_lo_i;
      div_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= num_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule : dsvu_div

`default_nettype wire

[rtl/dirichlet_semantic_voxel_update_top.sv]
// ----------------------------------------------------------------------------
// dirichlet_semantic_voxel_update_top
// Dirichlet class-count voxel: evidence update, decay, query of class posterior.
// ----------------------------------------------------------------------------
// One voxel holds NUM_CLASSES class counts in unsigned Q16.16. Each input
// transfer applies one operation (add evidence with saturation, decay of the
// dynamic classes by 2/3 or to zero at or below 1.0, load of the dynamic
// classes, reset of one class to the prior, or query; codes 5..7 act as a
// query) and yields exactly one output transfer with the first argmax class,
// the occupied and decayed flags, and the Q1.16 probability and Q0.24
// variance of the selected class. One lane per class updates its count in
// the accept cycle; a merge stage then registers the total, the argmax and
// the selected count. Probability and variance come from one shared
// restoring divider that retires 4 quotient bits per cycle (20 quotient bits
// for the probability, 24 for the variance), with a 17x17 multiply between
// them. When the total is zero or the selected class does not exist, both
// results are zero and the divisions are skipped. The output register is
// loaded from the done state once it is free or being read. One item is in
// work at a time; the next is accepted once the block is back in idle, which
// it enters at the edge that loads the output register, even while the
// previous result still waits in the output register.
// Configuration writes are taken at any time but are meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module dirichlet_semantic_voxel_update_top #(
  parameter int NUM_CLASSES = dsvu_pkg::NUM_CLASSES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [dsvu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [dsvu_pkg::PRIOR_W-1:0]      cfg_data_i,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [2:0] operation, [4:3] class_select, [36:5] evidence_0, [68:37] evidence_1,
  // [100:69] evidence_2, [132:101] evidence_3, [135:133] zero
  input  wire logic [dsvu_pkg::S_DATA_W-1:0]     s_axis_tdata,
  // output stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [1:0] semantic_class, [2] occupied, [3] decayed, [20:4] probability,
  // [44:21] variance, [47:45] zero
  output logic      [dsvu_pkg::M_DATA_W-1:0]     m_axis_tdata
);
  import dsvu_pkg::*;

  localparam int IW = $clog2(NUM_CLASSES);
  localparam int TW = CNT_W + $clog2(NUM_CLASSES);  // exact total
  localparam int DW = TW + 1;                       // total + 1.0

  // configuration registers
  logic [PRIOR_W-1:0] prior_q;
  logic [MASK_W-1:0]  mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q <= PRIOR_RESET;
      mask_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PRIOR:    prior_q <= cfg_data_i;
        REG_DYN_MASK: mask_q  <= cfg_data_i[MASK_W-1:0];
        default:      prior_q <= prior_q;
      endcase
    end
  end

  // input field unpacking
  op_e                         in_op;
  logic [SEL_W-1:0]            in_sel;
  logic [EV_NUM-1:0][CNT_W-1:0] in_ev;
  logic                        s_xfer;

  assign in_op  = op_e'(s_axis_tdata[OP_W-1:0]);
  assign in_sel = s_axis_tdata[OP_W +: SEL_W];
  for (genvar e = 0; e < EV_NUM; e++) begin : g_ev
    assign in_ev[e] = s_axis_tdata[OP_W + SEL_W + e*CNT_W +: CNT_W];
  end

  state_e state_q, state_d;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  // class lanes: counts update in the accept cycle
  logic [NUM_CLASSES-1:0][CNT_W-1:0] counts;
  logic [NUM_CLASSES-1:0]            lane_div;

  for (genvar i = 0; i < NUM_CLASSES; i++) begin : g_lane
    logic [CNT_W-1:0] evid;
    logic             dyn;
    if (i < EV_NUM) begin : g_ev_lane
      assign evid = in_ev[i];
      assign dyn  = mask_q[i];
    end else begin : g_plain_lane
      assign evid = '0;
      assign dyn  = 1'b0;
    end
    dsvu_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (s_xfer),
      .op_i      (in_op),
      .evid_i    (evid),
      .dyn_i     (dyn),
      .prior_i   (prior_q),
      .hit_i     (32'(in_sel) == i),
      .count_o   (counts[i]),
      .divided_o (lane_div[i])
    );
  end

  logic [SEL_W-1:0] sel_q;
  logic             decayed_q;

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      sel_q     <= in_sel;
      decayed_q <= |lane_div;
    end
  end

  // merge stage
  logic             merge_ld;
  logic [TW-1:0]    total;
  logic [IW-1:0]    best;
  logic [CNT_W-1:0] sel_count;
  logic             sel_ok;

  dsvu_merge #(
    .NUM_CLASSES (NUM_CLASSES),
    .IW          (IW),
    .TW          (TW)
  ) u_merge (
    .clk_i       (clk_i),
    .load_i      (merge_ld),
    .counts_i    (counts),
    .sel_i       (sel_q),
    .total_o     (total),
    .best_o      (best),
    .sel_count_o (sel_count),
    .sel_ok_o    (sel_ok)
  );

  // shared divider
  div_req_t         div_req;
  logic [DW-1:0]    div_rem, div_den;
  logic [QUO_W-1:0] div_lo;
  logic             div_done;
  logic [QUO_W-1:0] div_quo;

  logic [PROB_W-1:0]   prob_q;
  logic [VAR_W-1:0]    var_q;
  logic [2*PROB_W-1:0] mul_prod;
  logic [30:0]         pq_q;   // p*(1-p) in Q0.32, at most 2^30

  assign mul_prod = (2*PROB_W)'(prob_q) * (2*PROB_W)'(ONE_Q16 - prob_q);

  // probability: (count << 16) / total, 20 quotient bits
  // variance:    (pq << 8) / (total + 1.0), 24 quotient bits
  always_comb begin
    if (state_q == ST_VAR) begin
      div_rem = DW'(pq_q[30:16]);
      div_lo  = {pq_q[15:0], 8'b0};
      div_den = DW'(total) + DW'(ONE_Q16);
    end else begin
      div_rem = DW'(sel_count[CNT_W-1:DIV_STEP]);
      div_lo  = {sel_count[DIV_STEP-1:0], 20'b0};
      div_den = DW'(total);
    end
  end

  dsvu_div #(
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .rem_init_i (div_rem),
    .num_lo_i   (div_lo),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  // sequencer
  logic zero_ld, prob_ld, mul_ld, var_ld, out_ld;
  logic m_valid_q;

  always_comb begin
    state_d  = state_q;
    merge_ld = 1'b0;
    div_req  = '{start: 1'b0, chunks: PROB_CHUNKS};
    zero_ld  = 1'b0;
    prob_ld  = 1'b0;
    mul_ld   = 1'b0;
    var_ld   = 1'b0;
    out_ld   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_xfer) state_d = ST_MERGE;
      end
      ST_MERGE: begin
        merge_ld = 1'b1;
        state_d  = ST_PROB;
      end
      ST_PROB: begin
        if (!sel_ok || (total == '0)) begin
          zero_ld = 1'b1;
          state_d = ST_DONE;
        end else begin
          div_req = '{start: 1'b1, chunks: PROB_CHUNKS};
          state_d = ST_PWAIT;
        end
      end
      ST_PWAIT: begin
        if (div_done) begin
          prob_ld = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_ld  = 1'b1;
        state_d = ST_VAR;
      end
      ST_VAR: begin
        div_req = '{start: 1'b1, chunks: VAR_CHUNKS};
        state_d = ST_VWAIT;
      end
      ST_VWAIT: begin
        if (div_done) begin
          var_ld  = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_ld  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (zero_ld) begin
      prob_q <= '0;
      var_q  <= '0;
    end else begin
      if (prob_ld) prob_q <= div_quo[PROB_W-1:0];
      if (var_ld)  var_q  <= div_quo[VAR_W-1:0];
    end
    if (mul_ld) pq_q <= mul_prod[30:0];
  end

  // output register
  logic [CLASS_W-1:0] out_class_q;
  logic               out_occ_q, out_dec_q;
  logic [PROB_W-1:0]  out_prob_q;
  logic [VAR_W-1:0]   out_var_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_ld) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_class_q <= CLASS_W'(best);
      out_occ_q   <= best != '0;
      out_dec_q   <= decayed_q;
      out_prob_q  <= prob_q;
      out_var_q   <= var_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b0, out_var_q, out_prob_q, out_dec_q, out_occ_q, out_class_q};

`ifndef SYNTHESIS
  a_accept_starts_merge : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> state_q == ST_MERGE)
    else $error("accepted item did not enter merge");

  a_div_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_PWAIT || state_q == ST_VWAIT))
    else $error("divider finished outside a wait state");

  a_prob_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> out_prob_q <= ONE_Q16)
    else $error("probability above 1.0");

  a_out_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ld |-> (!m_valid_q || m_axis_tready))
    else $error("output register overwritten while held");
`endif

endmodule : dirichlet_semantic_voxel_update_top

`default_nettype wire
